// ===== hw/rtl/sep_pkg.sv =====
// Shared types, constants and codes for the Euler-Maruyama path stepper.
// Used by the controller, the datapath and the top level; depends on nothing.
package sep_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
    localparam int UVAL_WIDTH  = VALUE_WIDTH - 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int KIND_W      = 2;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [UVAL_WIDTH-1:0]         t_uvalue;
    typedef logic [KIND_W-1:0]             t_kind;

    localparam t_kind KIND_BM  = 2'd0;
    localparam t_kind KIND_GBM = 2'd1;
    localparam t_kind KIND_OU  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MU    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THETA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 3'd7;

    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_MU_DT = 3'd0;
    localparam t_mul_sel MUL_SG_DW = 3'd1;
    localparam t_mul_sel MUL_X_T1  = 3'd2;
    localparam t_mul_sel MUL_TH_T1 = 3'd3;
    localparam t_mul_sel MUL_T1_DT = 3'd4;

    typedef logic [2:0] t_t1_op;
    localparam t_t1_op T1_HOLD = 3'd0;
    localparam t_t1_op T1_XMU  = 3'd1;
    localparam t_t1_op T1_FIX  = 3'd2;
    localparam t_t1_op T1_SUM  = 3'd3;
    localparam t_t1_op T1_DIFF = 3'd4;

    typedef logic [1:0] t_dx_sel;
    localparam t_dx_sel DX_T1   = 2'd0;
    localparam t_dx_sel DX_FIX  = 2'd1;
    localparam t_dx_sel DX_ZERO = 2'd2;

    typedef struct packed {
        logic     accept;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_t1_op   t1_op;
        logic     t2_we;
        logic     commit;
        t_dx_sel  dx_sel;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
    } t_status;

endpackage

// ===== hw/rtl/sep_if.sv =====
// Handshake channels of the path stepper: one for noise beats, one for result beats.
// Depends on sep_pkg for the value type.
interface sep_in_if;
    import sep_pkg::*;

    logic   valid;
    logic   ready;
    t_value noise_increment;
    logic   path_last;

    modport source (output valid, output noise_increment, output path_last, input ready);
    modport sink   (input valid, input noise_increment, input path_last, output ready);
endinterface

interface sep_out_if;
    import sep_pkg::*;

    logic   valid;
    logic   ready;
    t_value path_value;
    logic   went_low;
    logic   went_high;
    logic   path_end;

    modport source (output valid, output path_value, output went_low, output went_high,
                    output path_end, input ready);
    modport sink   (input valid, input path_value, input went_low, input went_high,
                    input path_end, output ready);
endinterface

// ===== hw/rtl/sep_ctrl.sv =====
// Path stepper sequencer: walks beats of used kinds through the shared multiplier.
// Depends on sep_pkg for the command and status structures.
module sep_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  sep_pkg::t_status i_status,
    output sep_pkg::t_cmd    o_cmd
);
    import sep_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIFF  = 4'd1;
    localparam logic [3:0] ST_DRIFT = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_GBM   = 4'd4;
    localparam logic [3:0] ST_OU1   = 4'd5;
    localparam logic [3:0] ST_OU2   = 4'd6;
    localparam logic [3:0] ST_OU3   = 4'd7;
    localparam logic [3:0] ST_OU4   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_MU_DT;
        o_cmd.t1_op    = T1_HOLD;
        o_cmd.dx_sel   = DX_T1;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.kind == KIND_BM || i_status.kind == KIND_GBM ||
                        i_status.kind == KIND_OU) begin
                        n_state = ST_DIFF;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_DIFF: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SG_DW;
                if (i_status.kind == KIND_OU) begin
                    o_cmd.t1_op = T1_XMU;
                    n_state     = ST_OU1;
                end else begin
                    n_state = ST_DRIFT;
                end
            end
            ST_DRIFT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MU_DT;
                o_cmd.t2_we   = 1'b1;
                n_state       = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.t1_op = T1_SUM;
                n_state     = (i_status.kind == KIND_GBM) ? ST_GBM : ST_FIN;
            end
            ST_GBM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_X_T1;
                n_state       = ST_FIN;
            end
            ST_OU1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_TH_T1;
                o_cmd.t2_we   = 1'b1;
                n_state       = ST_OU2;
            end
            ST_OU2: begin
                o_cmd.t1_op = T1_FIX;
                n_state     = ST_OU3;
            end
            ST_OU3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_T1_DT;
                n_state       = ST_OU4;
            end
            ST_OU4: begin
                o_cmd.t1_op = T1_DIFF;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.kind == KIND_GBM) begin
                    o_cmd.dx_sel = DX_FIX;
                end else if (i_status.kind == KIND_BM || i_status.kind == KIND_OU) begin
                    o_cmd.dx_sel = DX_T1;
                end else begin
                    o_cmd.dx_sel = DX_ZERO;
                end
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/sep_dpath.sv =====
// Datapath of the path stepper: settings, path state, shared multiplier and result register.
// Depends on sep_pkg for widths, codes and the command and status structures.
module sep_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [sep_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sep_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  sep_pkg::t_cmd                    i_cmd,
    output sep_pkg::t_status                 o_status,
    input  sep_pkg::t_value                  i_noise_increment,
    input  logic                             i_path_last,
    output sep_pkg::t_value                  o_path_value,
    output logic                             o_went_low,
    output logic                             o_went_high,
    output logic                             o_path_end
);
    import sep_pkg::*;

    localparam int SHIFT_WIDTH = PROD_WIDTH - FRAC_BITS;
    localparam int SAT_BITS    = SHIFT_WIDTH - VALUE_WIDTH + 1;

    localparam t_value VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_value VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    function automatic t_value sat_add(input t_value a, input t_value b);
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

    function automatic t_value sat_sub(input t_value a, input t_value b);
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

    t_kind   r_kind;
    t_value  r_mu;
    t_uvalue r_sigma;
    t_uvalue r_theta;
    t_uvalue r_dt;
    t_value  r_start;
    t_value  r_lower;
    t_value  r_upper;

    t_value  r_x;
    logic    r_fresh;
    logic    r_low_seen;
    logic    r_high_seen;
    t_value  r_dw;
    logic    r_last;
    t_value  r_t1;
    t_value  r_t2;
    logic signed [PROD_WIDTH-1:0] r_prod;

    t_value  r_out_value;
    logic    r_out_low;
    logic    r_out_high;
    logic    r_out_end;

    t_value  w_mul_a;
    t_value  w_mul_b;
    logic signed [PROD_WIDTH-1:0]  w_prod;
    logic signed [SHIFT_WIDTH-1:0] w_shift;
    logic [SAT_BITS-1:0]           w_top;
    t_value  w_fix;
    t_value  w_dx;
    t_value  w_x_new;
    logic    w_low;
    logic    w_high;

    assign o_status.kind = r_kind;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_MU_DT: begin
                w_mul_a = r_mu;
                w_mul_b = {1'b0, r_dt};
            end
            MUL_SG_DW: begin
                w_mul_a = {1'b0, r_sigma};
                w_mul_b = r_dw;
            end
            MUL_X_T1: begin
                w_mul_a = r_x;
                w_mul_b = r_t1;
            end
            MUL_TH_T1: begin
                w_mul_a = {1'b0, r_theta};
                w_mul_b = r_t1;
            end
            MUL_T1_DT: begin
                w_mul_a = r_t1;
                w_mul_b = {1'b0, r_dt};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod  = PROD_WIDTH'(w_mul_a) * PROD_WIDTH'(w_mul_b);
    assign w_shift = r_prod[PROD_WIDTH-1:FRAC_BITS];
    assign w_top   = w_shift[SHIFT_WIDTH-1:VALUE_WIDTH-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            w_fix = w_shift[VALUE_WIDTH-1:0];
        end else begin
            w_fix = w_top[SAT_BITS-1] ? VMIN : VMAX;
        end
    end

    always_comb begin
        case (i_cmd.dx_sel)
            DX_T1:   w_dx = r_t1;
            DX_FIX:  w_dx = w_fix;
            default: w_dx = '0;
        endcase
    end

    assign w_x_new = sat_add(r_x, w_dx);
    assign w_low   = (w_x_new <= r_lower);
    assign w_high  = (w_x_new >= r_upper);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_BM;
            r_mu    <= '0;
            r_sigma <= UVAL_WIDTH'(1) << FRAC_BITS;
            r_theta <= '0;
            r_dt    <= UVAL_WIDTH'(1) << FRAC_BITS;
            r_start <= '0;
            r_lower <= VMIN;
            r_upper <= VMAX;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_KIND:  r_kind  <= i_cfg_wdata[KIND_W-1:0];
                REG_MU:    r_mu    <= i_cfg_wdata[VALUE_WIDTH-1:0];
                REG_SIGMA: r_sigma <= i_cfg_wdata[UVAL_WIDTH-1:0];
                REG_THETA: r_theta <= i_cfg_wdata[UVAL_WIDTH-1:0];
                REG_DT:    r_dt    <= i_cfg_wdata[UVAL_WIDTH-1:0];
                REG_START: r_start <= i_cfg_wdata[VALUE_WIDTH-1:0];
                REG_LOWER: r_lower <= i_cfg_wdata[VALUE_WIDTH-1:0];
                REG_UPPER: r_upper <= i_cfg_wdata[VALUE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_fresh     <= 1'b1;
            r_low_seen  <= 1'b0;
            r_high_seen <= 1'b0;
        end else if (i_cmd.accept) begin
            if (r_fresh) begin
                r_x         <= r_start;
                r_fresh     <= 1'b0;
                r_low_seen  <= 1'b0;
                r_high_seen <= 1'b0;
            end
        end else if (i_cmd.commit) begin
            r_x         <= w_x_new;
            r_fresh     <= r_last;
            r_low_seen  <= r_low_seen | w_low;
            r_high_seen <= r_high_seen | w_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dw   <= i_noise_increment;
            r_last <= i_path_last;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.t2_we) begin
            r_t2 <= w_fix;
        end
        case (i_cmd.t1_op)
            T1_XMU:  r_t1 <= sat_sub(r_x, r_mu);
            T1_FIX:  r_t1 <= w_fix;
            T1_SUM:  r_t1 <= sat_add(w_fix, r_t2);
            T1_DIFF: r_t1 <= sat_sub(r_t2, w_fix);
            default: begin
            end
        endcase
        if (i_cmd.commit) begin
            r_out_value <= w_x_new;
            r_out_low   <= r_low_seen | w_low;
            r_out_high  <= r_high_seen | w_high;
            r_out_end   <= r_last;
        end
    end

    assign o_path_value = r_out_value;
    assign o_went_low   = r_out_low;
    assign o_went_high  = r_out_high;
    assign o_path_end   = r_out_end;

endmodule

// ===== hw/rtl/sde_euler_path_stepper_top.sv =====
// Top level of the Euler-Maruyama path stepper: ties the sequencer to the datapath.
// Depends on sep_pkg, the channel interfaces in sep_if, sep_ctrl and sep_dpath.
//
// Each beat on i_item carries one scaled noise increment and a last-of-path flag; each
// accepted beat gives exactly one beat on o_result with the new path value, the sticky
// low and high crossing flags and the end-of-path marker. The first beat of a path starts
// from the start value and clears both flags; a beat flagged last makes the next one do so.
// Settings are written through the i_cfg_* port, one register per cycle; the user must
// write them only while idle, as the block itself does not enforce this. One beat is
// in work at a time and all multiplies run through one shared multiplier. How many
// dependent multiplies a beat goes through is set by its kind, and the unused kind has
// none. i_item is ready again in the cycle the result is shown, so the block takes a new
// beat only once it is done with the previous one, whatever its kind.
// The result register holds a finished beat while the receiver stalls, and the next beat
// is accepted and worked on meanwhile; it waits at its last step until the register is free.
// Reset is synchronous and active low: it restores the settings to their defaults, empties
// the result register and marks the next beat as the start of a new path.
module sde_euler_path_stepper_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [sep_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sep_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    sep_in_if.sink                         i_item,
    sep_out_if.source                      o_result
);
    import sep_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sep_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_noise_increment (i_item.noise_increment),
        .i_path_last       (i_item.path_last),
        .o_path_value      (o_result.path_value),
        .o_went_low        (o_result.went_low),
        .o_went_high       (o_result.went_high),
        .o_path_end        (o_result.path_end)
    );

endmodule
